// ===== src/stack_machine_execute_unit_defines.svh =====
// assertion macros for the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/sme_pkg.sv =====
package sme_pkg;
    localparam int STACK_DEPTH    = 64;
    localparam int RET_DEPTH      = 16;
    localparam int NUM_REGS       = 4;
    localparam int RAM_WORDS      = 1024;
    localparam int CODE_ADDR_BITS = 12;

    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int RP_W   = $clog2(RET_DEPTH);
    localparam int RA_W   = $clog2(RAM_WORDS);
    localparam int RN_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SD_W   = SP_W + 1;
    localparam int RD_W   = RP_W + 1;

    typedef enum logic [4:0] {
        CMD_HALT  = 5'd0,  CMD_PUSH  = 5'd1,  CMD_OUT  = 5'd2,  CMD_ADD  = 5'd3,
        CMD_SUB   = 5'd4,  CMD_MUL   = 5'd5,  CMD_DIV  = 5'd6,  CMD_MOD  = 5'd7,
        CMD_SQRT  = 5'd8,  CMD_IN    = 5'd9,  CMD_POPR = 5'd10, CMD_PUSHR = 5'd11,
        CMD_CALL  = 5'd12, CMD_RET   = 5'd13, CMD_PUSHM = 5'd14, CMD_POPM = 5'd15,
        CMD_JMP   = 5'd16, CMD_JB    = 5'd17, CMD_JBE  = 5'd18, CMD_JA   = 5'd19,
        CMD_JAE   = 5'd20, CMD_JE    = 5'd21, CMD_JNE  = 5'd22
    } cmd_t;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER = 3'd2;
    localparam logic [2:0] ERR_DIV0 = 3'd3;
    localparam logic [2:0] ERR_RET = 3'd4;
    localparam logic [2:0] ERR_RAM = 3'd5;
    localparam logic [2:0] ERR_SQRT = 3'd6;

    // decoded word handed from front to back
    typedef struct packed {
        logic [4:0]  command;
        logic [31:0] immediate;
        logic [CODE_ADDR_BITS-1:0] target;
        logic [2:0]  reg_number;
        logic [31:0] in_value;
        logic        pops_one;
        logic        pops_two;
        logic        pushes;
        logic        is_iter;
    } dec_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_ITER, ST_RAMRD, ST_RAMWAIT, ST_DONE, ST_CLEAR
    } st_t;

    typedef enum logic [1:0] {
        IT_DIV, IT_MOD, IT_SQRT
    } it_t;
endpackage

// ===== src/stack_machine_execute_unit.sv =====
// stack machine execute unit
// in channel: in_valid / in_stall carry one decoded instruction word
// (command, immediate, target, reg_number, in_value)
// out channel: out_word_valid / out_word_stall carry one result word per
// instruction (next_pc, out_valid, out_value, error_code, halted)
// a two-entry queue sits between the classifying front end and the executor,
// so the front takes up to two words while the executor or the receiver waits
// add/sub/mul and compares pass through the ITER state and pushm through
// RAMRD; div, mod and sqrt run on the shared one-bit-per-cycle iterative unit
// the executor works on one word at a time; with words queued it takes the
// next one as it returns to idle after handing a result to the output
// after reset all 1024 words of the data ram are cleared, one word a cycle,
// and no word is executed before that; the queue may fill meanwhile
// a stalled result holds in the output register; the executor then waits
// with its next finished result
`include "stack_machine_execute_unit_defines.svh"
module stack_machine_execute_unit import sme_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [4:0]                command,
    input  logic signed [31:0]        immediate,
    input  logic [CODE_ADDR_BITS-1:0] target,
    input  logic [2:0]                reg_number,
    input  logic signed [31:0]        in_value,
    output logic                      out_word_valid,
    input  logic                      out_word_stall,
    output logic [CODE_ADDR_BITS-1:0] next_pc,
    output logic                      out_valid,
    output logic signed [31:0]        out_value,
    output logic [2:0]                error_code,
    output logic                      halted
);
    logic q_valid;
    logic q_take;
    dec_t q_word;

    sme_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .command(command), .immediate(immediate), .target(target),
        .reg_number(reg_number), .in_value(in_value),
        .q_valid(q_valid), .q_word(q_word), .q_take(q_take));

    sme_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .q_take(q_take),
        .res_valid(out_word_valid), .res_stall(out_word_stall), .next_pc(next_pc),
        .out_valid(out_valid), .out_value(out_value), .error_code(error_code),
        .halted(halted));

    `SM_ASSERT_IMP(a_outval_zero, clk, rst_n, out_word_valid && !out_valid, out_value == 32'd0)
    `SM_ASSERT_IMP(a_err_halts, clk, rst_n, out_word_valid && error_code != ERR_NONE, halted)
    `SM_ASSERT_NEXT(a_hold, clk, rst_n, out_word_valid && out_word_stall, out_word_valid && $stable(next_pc))
    `SM_ASSERT_IMP(a_no_print_err, clk, rst_n, out_word_valid && out_valid, error_code == ERR_NONE)
endmodule

// ===== src/sme_ram.sv =====
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/sme_front.sv =====
module sme_front import sme_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid,
    output logic                      stall,
    input  logic [4:0]                command,
    input  logic signed [31:0]        immediate,
    input  logic [CODE_ADDR_BITS-1:0] target,
    input  logic [2:0]                reg_number,
    input  logic signed [31:0]        in_value,
    output logic                      q_valid,
    output dec_t                      q_word,
    input  logic                      q_take
);
    // two-entry queue of classified words
    dec_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg;
    logic       wp_reg;
    dec_t       d;
    logic       push;

    always_comb
    begin
        d = '0;
        d.command = command;
        d.immediate = immediate;
        d.target = target;
        d.reg_number = reg_number;
        d.in_value = in_value;
        d.pops_two = (command >= CMD_ADD && command <= CMD_MOD) ||
                     (command >= CMD_JB && command <= CMD_JNE);
        d.pops_one = command == CMD_OUT || command == CMD_SQRT || command == CMD_POPR ||
                     command == CMD_POPM;
        d.pushes = command == CMD_PUSH || command == CMD_IN || command == CMD_PUSHR ||
                   command == CMD_PUSHM;
        d.is_iter = command == CMD_DIV || command == CMD_MOD || command == CMD_SQRT;
    end

    assign stall = cnt_reg == 2'd2;
    assign push = valid && !stall;
    assign q_valid = cnt_reg != 2'd0;
    assign q_word = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg <= 1'b0;
            wp_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_take && q_valid)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_take && q_valid);
        end
    end
endmodule

// ===== src/sme_iter.sv =====
module sme_iter import sme_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  it_t         op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result
);
    // shared restoring divider / digit-by-digit square root, one bit per cycle
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] v_reg, v_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    it_t         op_reg;
    logic        na_reg, nb_reg;
    logic [32:0] trial;
    logic [33:0] sqt;
    logic [31:0] sres;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        sq_next = sq_reg;
        v_next = v_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = '0;
        sqt = '0;
        if (busy_reg)
        begin
            if (op_reg == IT_SQRT)
            begin
                // r holds remainder, sq the root so far
                r_next = {r_reg[30:0], v_reg[31:30]};
                v_next = {v_reg[29:0], 2'b00};
                sqt = {1'b0, r_next} - {sq_reg, 2'b01};
                if (!sqt[33])
                begin
                    r_next = sqt[32:0];
                    sq_next = {sq_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_next = {sq_reg[30:0], 1'b0};
                end
            end
            else
            begin
                trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
                if (!trial[32])
                begin
                    r_next = trial;
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[31:0], q_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= op;
            na_reg <= a[31];
            nb_reg <= b[31];
            q_reg <= a[31] ? 32'(0 - a) : a;
            d_reg <= b[31] ? 32'(0 - b) : b;
            r_reg <= '0;
            sq_reg <= '0;
            v_reg <= a;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
            sq_reg <= sq_next;
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= busy_reg && !busy_next;
            if (start)
            begin
                busy_reg <= 1'b1;
                n_reg <= (op == IT_SQRT) ? 6'd16 : 6'd32;
            end
            else
            begin
                busy_reg <= busy_next;
                n_reg <= n_next;
            end
        end
    end

    assign sres = sq_reg;
    always_comb
    begin
        unique case (op_reg)
            IT_DIV:  result = (na_reg ^ nb_reg) ? 32'(0 - q_reg) : q_reg;
            IT_MOD:  result = na_reg ? 32'(0 - r_reg[31:0]) : r_reg[31:0];
            default: result = sres;
        endcase
    end
endmodule

// ===== src/sme_back.sv =====
module sme_back import sme_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  dec_t                      q_word,
    output logic                      q_take,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [CODE_ADDR_BITS-1:0] next_pc,
    output logic                      out_valid,
    output logic signed [31:0]        out_value,
    output logic [2:0]                error_code,
    output logic                      halted
);
    st_t st_reg, st_next;
    dec_t w_reg;
    logic [SD_W-1:0] dd_reg, dd_next;
    logic [RD_W-1:0] rd_reg, rd_next;
    logic [31:0] regs_reg [NUM_REGS];
    logic [CODE_ADDR_BITS-1:0] pc_reg, pc_next;
    logic stop_reg, stop_next;
    logic [31:0] b_reg, b_next, a_reg, a_next;
    logic [31:0] mul_reg;
    logic [RA_W-1:0] clr_reg;

    logic ds_we; logic [SP_W-1:0] ds_wa, ds_ra; logic [31:0] ds_wd, ds_rd;
    logic rs_we; logic [RP_W-1:0] rs_wa; logic [CODE_ADDR_BITS-1:0] rs_wd, rs_rd;
    logic rm_we; logic [RA_W-1:0] rm_wa, rm_ra; logic [31:0] rm_wd, rm_rd;
    logic it_start, it_done; it_t it_op; logic [31:0] it_res;

    logic [CODE_ADDR_BITS-1:0] o_pc_reg, o_pc_next;
    logic o_ov_reg, o_ov_next;
    logic [31:0] o_val_reg, o_val_next;
    logic [2:0] o_err_reg, o_err_next;
    logic o_halt_reg, o_halt_next;
    logic ovld_reg, ovld_next;

    // result word as presented on the output channel
    logic r_ov_reg;
    logic [31:0] r_val_reg;
    logic [2:0] r_err_reg;
    logic r_halt_reg;
    logic res_load;

    logic [31:0] rval;
    logic rn_ok;
    logic [RN_W-1:0] rn_idx;
    logic [CODE_ADDR_BITS-1:0] pc1, pc2;
    logic take;
    logic reg_we;
    logic [31:0] reg_wd;
    logic [31:0] alu;

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ds (
        .clk(clk), .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
    sme_ram #(.WIDTH(CODE_ADDR_BITS), .DEPTH(RET_DEPTH)) u_rs (
        .clk(clk), .we(rs_we), .waddr(rs_wa), .wdata(rs_wd),
        .raddr(RP_W'(rd_reg - RD_W'(1))), .rdata(rs_rd));
    sme_ram #(.WIDTH(32), .DEPTH(RAM_WORDS)) u_rm (
        .clk(clk), .we(rm_we), .waddr(rm_wa), .wdata(rm_wd), .raddr(rm_ra), .rdata(rm_rd));
    sme_iter u_it (
        .clk(clk), .rst_n(rst_n), .start(it_start), .op(it_op), .a(a_reg), .b(b_reg),
        .done(it_done), .result(it_res));

    assign rn_ok = w_reg.reg_number >= 3'd1 && 32'(w_reg.reg_number) <= NUM_REGS;
    assign rn_idx = RN_W'(w_reg.reg_number - 3'd1);
    assign rval = rn_ok ? regs_reg[rn_idx] : 32'd0;
    assign pc1 = pc_reg + CODE_ADDR_BITS'(1);
    assign pc2 = pc_reg + CODE_ADDR_BITS'(2);
    assign rm_ra = RA_W'(rval);
    assign rs_wa = RP_W'(rd_reg);
    assign rs_wd = pc2;
    assign res_load = st_reg == ST_DONE && (!ovld_reg || !res_stall);

    always_comb
    begin
        unique case (w_reg.command)
            CMD_JB:  take = $signed(a_reg) < $signed(b_reg);
            CMD_JBE: take = $signed(a_reg) <= $signed(b_reg);
            CMD_JA:  take = $signed(a_reg) > $signed(b_reg);
            CMD_JAE: take = $signed(a_reg) >= $signed(b_reg);
            CMD_JE:  take = a_reg == b_reg;
            default: take = a_reg != b_reg;
        endcase
        unique case (w_reg.command)
            CMD_ADD: alu = a_reg + b_reg;
            CMD_SUB: alu = a_reg - b_reg;
            default: alu = mul_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        // product of the operands as they are loaded
        mul_reg <= 32'(a_next * b_next);
        if (st_reg == ST_IDLE && q_valid)
        begin
            w_reg <= q_word;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        o_pc_reg <= o_pc_next;
        o_ov_reg <= o_ov_next;
        o_val_reg <= o_val_next;
        o_err_reg <= o_err_next;
        o_halt_reg <= o_halt_next;
        if (res_load)
        begin
            r_ov_reg <= o_ov_reg;
            r_val_reg <= o_val_reg;
            r_err_reg <= o_err_reg;
            r_halt_reg <= o_halt_reg;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        dd_next = dd_reg;
        rd_next = rd_reg;
        pc_next = pc_reg;
        stop_next = stop_reg;
        a_next = a_reg;
        b_next = b_reg;
        ovld_next = ovld_reg && res_stall;
        o_pc_next = o_pc_reg;
        o_ov_next = o_ov_reg;
        o_val_next = o_val_reg;
        o_err_next = o_err_reg;
        o_halt_next = o_halt_reg;
        q_take = 1'b0;
        ds_we = 1'b0; ds_wa = SP_W'(dd_reg); ds_wd = '0; ds_ra = SP_W'(dd_reg - SD_W'(1));
        rs_we = 1'b0;
        rm_we = 1'b0; rm_wa = '0; rm_wd = '0;
        it_start = 1'b0; it_op = IT_DIV;
        reg_we = 1'b0; reg_wd = '0;
        unique case (st_reg)
            ST_CLEAR:
            begin
                rm_we = 1'b1; rm_wa = clr_reg;
                if (clr_reg == RA_W'(RAM_WORDS - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    st_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                // issue read of top; result appears next cycle
                ds_ra = SP_W'(dd_reg - SD_W'(1));
                o_pc_next = pc1; o_ov_next = 1'b0; o_val_next = '0;
                o_err_next = ERR_NONE; o_halt_next = 1'b0;
                if (stop_reg)
                begin
                    o_pc_next = pc_reg; o_halt_next = 1'b1; st_next = ST_DONE;
                end
                else if ((w_reg.pops_two && dd_reg < SD_W'(2)) ||
                         (w_reg.pops_one && dd_reg == '0))
                begin
                    o_pc_next = pc_reg; o_err_next = ERR_UNDER; o_halt_next = 1'b1;
                    stop_next = 1'b1; st_next = ST_DONE;
                end
                else
                begin
                    st_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                ds_ra = SP_W'(dd_reg - SD_W'(2));
                b_next = ds_rd;
                st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (w_reg.pops_two) a_next = ds_rd;
                st_next = ST_DONE;
                priority case (1'b1)
                    w_reg.command == CMD_HALT:
                    begin
                        o_pc_next = pc_reg; o_halt_next = 1'b1; stop_next = 1'b1;
                    end
                    w_reg.command == CMD_PUSH || w_reg.command == CMD_IN ||
                    w_reg.command == CMD_PUSHR:
                    begin
                        if (dd_reg == SD_W'(STACK_DEPTH))
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_OVER; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            ds_we = 1'b1;
                            ds_wd = (w_reg.command == CMD_PUSH) ? w_reg.immediate :
                                    (w_reg.command == CMD_IN) ? w_reg.in_value : rval;
                            dd_next = dd_reg + SD_W'(1);
                            if (w_reg.command != CMD_IN) o_pc_next = pc2;
                        end
                    end
                    w_reg.command == CMD_OUT:
                    begin
                        o_ov_next = 1'b1; o_val_next = b_reg; dd_next = dd_reg - SD_W'(1);
                    end
                    w_reg.command == CMD_ADD || w_reg.command == CMD_SUB ||
                    w_reg.command == CMD_MUL:
                    begin
                        st_next = ST_ITER; // go through ITER so the product register is loaded
                    end
                    w_reg.command == CMD_DIV || w_reg.command == CMD_MOD:
                    begin
                        if (b_reg == '0)
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_DIV0; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            st_next = ST_RAMWAIT;
                        end
                    end
                    w_reg.command == CMD_SQRT:
                    begin
                        if (b_reg[31])
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_SQRT; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            a_next = b_reg;
                            st_next = ST_RAMWAIT;
                        end
                    end
                    w_reg.command == CMD_POPR:
                    begin
                        reg_we = rn_ok; reg_wd = b_reg;
                        dd_next = dd_reg - SD_W'(1); o_pc_next = pc2;
                    end
                    w_reg.command == CMD_CALL:
                    begin
                        if (rd_reg == RD_W'(RET_DEPTH))
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_RET; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            rs_we = 1'b1; rd_next = rd_reg + RD_W'(1);
                            o_pc_next = w_reg.target;
                        end
                    end
                    w_reg.command == CMD_RET:
                    begin
                        if (rd_reg == '0)
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_RET; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            rd_next = rd_reg - RD_W'(1); o_pc_next = rs_rd;
                        end
                    end
                    w_reg.command == CMD_PUSHM || w_reg.command == CMD_POPM:
                    begin
                        if (rval[31] || rval >= 32'(RAM_WORDS))
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_RAM; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else if (w_reg.command == CMD_POPM)
                        begin
                            rm_we = 1'b1; rm_wa = RA_W'(rval); rm_wd = b_reg;
                            dd_next = dd_reg - SD_W'(1); o_pc_next = pc2;
                        end
                        else if (dd_reg == SD_W'(STACK_DEPTH))
                        begin
                            o_pc_next = pc_reg; o_err_next = ERR_OVER; o_halt_next = 1'b1;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            st_next = ST_RAMRD;
                        end
                    end
                    w_reg.command == CMD_JMP:
                    begin
                        o_pc_next = w_reg.target;
                    end
                    w_reg.command >= CMD_JB && w_reg.command <= CMD_JNE:
                    begin
                        st_next = ST_ITER;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RAMWAIT:
            begin
                // start the iterative unit with operands now settled
                it_start = 1'b1;
                it_op = (w_reg.command == CMD_DIV) ? IT_DIV :
                        (w_reg.command == CMD_MOD) ? IT_MOD : IT_SQRT;
                st_next = ST_ITER;
            end
            ST_RAMRD:
            begin
                ds_we = 1'b1; ds_wd = rm_rd; dd_next = dd_reg + SD_W'(1); o_pc_next = pc2;
                st_next = ST_DONE;
            end
            ST_ITER:
            begin
                if (w_reg.command >= CMD_JB && w_reg.command <= CMD_JNE)
                begin
                    dd_next = dd_reg - SD_W'(2);
                    o_pc_next = take ? w_reg.target : pc2;
                    st_next = ST_DONE;
                end
                else if (w_reg.command == CMD_ADD || w_reg.command == CMD_SUB ||
                         w_reg.command == CMD_MUL)
                begin
                    ds_we = 1'b1; ds_wa = SP_W'(dd_reg - SD_W'(2)); ds_wd = alu;
                    dd_next = dd_reg - SD_W'(1); st_next = ST_DONE;
                end
                else if (it_done)
                begin
                    ds_we = 1'b1;
                    if (w_reg.command == CMD_SQRT)
                    begin
                        ds_wa = SP_W'(dd_reg - SD_W'(1));
                    end
                    else
                    begin
                        ds_wa = SP_W'(dd_reg - SD_W'(2)); dd_next = dd_reg - SD_W'(1);
                    end
                    ds_wd = it_res; st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ovld_reg || !res_stall)
                begin
                    ovld_next = 1'b1;
                    pc_next = o_pc_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLEAR;
            clr_reg <= '0;
            dd_reg <= '0;
            rd_reg <= '0;
            pc_reg <= '0;
            stop_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + RA_W'(1);
            end
            dd_reg <= dd_next;
            rd_reg <= rd_next;
            pc_reg <= pc_next;
            stop_reg <= stop_next;
            ovld_reg <= ovld_next;
        end
    end

    // general registers reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (reg_we)
        begin
            regs_reg[rn_idx] <= reg_wd;
        end
    end

    assign res_valid = ovld_reg;
    assign next_pc = pc_reg;
    assign out_valid = r_ov_reg;
    assign out_value = r_val_reg;
    assign error_code = r_err_reg;
    assign halted = r_halt_reg;
endmodule
